// ----- hw/rtl/simple_moving_average_unit_assert.svh -----
`ifndef SIMPLE_MOVING_AVERAGE_UNIT_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SMA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define SMA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/sma_pkg.sv -----
package sma_pkg;

   localparam int MaxWindow = 64;
   localparam int DataW     = 32;
   localparam int CfgW      = 7;
   localparam int PtrW      = $clog2(MaxWindow);
   localparam int CntW      = $clog2(MaxWindow + 1);
   localparam int SumW      = DataW + PtrW;
   localparam int StepW     = $clog2(SumW);

   typedef struct packed {
      logic capture;
      logic subtract;
      logic add;
      logic div_step;
      logic out_load;
   } sma_cmd_type;

   typedef struct packed {
      logic res_due;
      logic div_last;
      logic out_free;
   } sma_status_type;

   function automatic logic [CntW-1:0] legal_length(input logic [CfgW-1:0] value);
      logic [CntW-1:0] len;
      len = CntW'(value);
      if (value == '0) begin
         len = CntW'(1);
      end else if (int'(value) > MaxWindow) begin
         len = CntW'(MaxWindow);
      end
      return len;
   endfunction

endpackage

// ----- hw/rtl/sma_ram.sv -----
module sma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sma_ctrl.sv -----
`include "simple_moving_average_unit_assert.svh"

module sma_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sma_pkg::sma_status_type status,
   output sma_pkg::sma_cmd_type    cmd
);

   typedef enum logic [4:0] {
      IDLE     = 5'b00001,
      SUBTRACT = 5'b00010,
      ADD      = 5'b00100,
      DIVIDE   = 5'b01000,
      DELIVER  = 5'b10000
   } sma_state_type;

   sma_state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = SUBTRACT;
            end
         end
         SUBTRACT: begin
            cmd.subtract = 1'b1;
            state_in     = ADD;
         end
         ADD: begin
            cmd.add  = 1'b1;
            state_in = status.res_due ? DIVIDE : IDLE;
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = DELIVER;
            end
         end
         DELIVER: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SMA_ASSERT_NEXT(a_accept_goes_subtract, req_tvalid && req_tready, state_ff == SUBTRACT)
   `SMA_ASSERT_NEXT(a_last_step_delivers, state_ff == DIVIDE && status.div_last,
                    state_ff == DELIVER)
   `SMA_ASSERT_NOW(a_load_needs_room, cmd.out_load, status.out_free)

endmodule

// ----- hw/rtl/sma_datapath.sv -----
`include "simple_moving_average_unit_assert.svh"

module sma_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [2*sma_pkg::DataW-1:0]  req_tdata,
   input  logic                         csr_valid,
   input  logic [sma_pkg::CfgW-1:0]     csr_wdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [2*sma_pkg::DataW-1:0]  rsp_tdata,
   input  sma_pkg::sma_cmd_type         cmd,
   output sma_pkg::sma_status_type      status
);

   localparam int DataW = sma_pkg::DataW;
   localparam int PtrW  = sma_pkg::PtrW;
   localparam int CntW  = sma_pkg::CntW;
   localparam int SumW  = sma_pkg::SumW;
   localparam int StepW = sma_pkg::StepW;

   logic [CntW-1:0]    len_ff, len_in;
   logic [PtrW-1:0]    wp_ff, wp_in;
   logic [CntW-1:0]    seen_ff, seen_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [DataW-1:0]   price_ff, price_in;
   logic [DataW-1:0]   tag_ff, tag_in;
   logic [SumW-1:0]    dd_ff, dd_in;
   logic [CntW-1:0]    rem_ff, rem_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic [2*DataW-1:0] out_data_ff, out_data_in;

   logic [DataW-1:0]   old_sample;
   logic               full;
   logic [SumW-1:0]    sum_added;
   logic [CntW:0]      wp_next;
   logic [CntW:0]      trial;
   logic               trial_ge;

   sma_ram #(
      .WIDTH (DataW),
      .DEPTH (sma_pkg::MaxWindow)
   ) u_history (
      .clock   (clock),
      .wr_en   (cmd.add),
      .wr_addr (wp_ff),
      .wr_data (price_ff),
      .rd_addr (wp_ff),
      .rd_data (old_sample)
   );

   assign full      = seen_ff >= len_ff;
   assign sum_added = sum_ff + SumW'(price_ff);
   assign wp_next   = (CntW + 1)'(wp_ff) + (CntW + 1)'(1);
   assign trial     = {rem_ff, dd_ff[SumW-1]};
   assign trial_ge  = trial >= {1'b0, len_ff};

   assign status.res_due  = ((CntW + 1)'(seen_ff) + (CntW + 1)'(1)) >= {1'b0, len_ff};
   assign status.div_last = step_ff == StepW'(SumW - 1);
   assign status.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      len_in       = len_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      price_in     = price_ff;
      tag_in       = tag_ff;
      dd_in        = dd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (cmd.capture) begin
         price_in = req_tdata[DataW-1:0];
         tag_in   = req_tdata[2*DataW-1:DataW];
      end

      priority if (csr_valid) begin
         len_in  = sma_pkg::legal_length(csr_wdata);
         wp_in   = '0;
         seen_in = '0;
         sum_in  = '0;
      end else if (cmd.subtract) begin
         if (full) begin
            sum_in = sum_ff - SumW'(old_sample);
         end
      end else if (cmd.add) begin
         sum_in  = sum_added;
         dd_in   = sum_added;
         rem_in  = '0;
         step_in = '0;
         if (!full) begin
            seen_in = seen_ff + CntW'(1);
         end
         wp_in = (wp_next >= {1'b0, len_ff}) ? '0 : wp_next[PtrW-1:0];
      end else if (cmd.div_step) begin
         rem_in  = trial_ge ? CntW'(trial - {1'b0, len_ff}) : CntW'(trial);
         dd_in   = {dd_ff[SumW-2:0], trial_ge};
         step_in = step_ff + StepW'(1);
      end else begin
      end

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_data_in  = {tag_ff, dd_ff[DataW-1:0]};
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= CntW'(1);
         wp_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      price_ff    <= price_in;
      tag_ff      <= tag_in;
      dd_ff       <= dd_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `SMA_ASSERT_NOW(a_seen_within_len, 1'b1, seen_ff <= len_ff)
   `SMA_ASSERT_NOW(a_pointer_within_len, 1'b1, CntW'(wp_ff) < len_ff)
   `SMA_ASSERT_NEXT(a_load_shows_word, cmd.out_load, out_valid_ff)

endmodule

// ----- hw/rtl/simple_moving_average_unit.sv -----
// simple moving average over the last window_len price samples
// req channel: one word per sample, accepted on req_tvalid && req_tready;
//   req_tdata[31:0] close_price (unsigned Q16.16), [63:32] sample_tag
// rsp channel: one word per sample once the window is full;
//   rsp_tdata[31:0] average (unsigned Q16.16, truncated), [63:32] tag_out
// csr channel: csr_wdata sets window_len (0 reads as 1, above 64 as 64) and
//   clears the history, pointer and running sum; write only while idle
// a sample takes two cycles to fold into the running sum, then a restoring
//   divider takes 38 cycles, one quotient bit per cycle, plus one to load
//   the output register: rsp_tvalid rises 41 cycles after the accept
// throughput: one sample per 42 cycles when it yields a result, one per
//   3 cycles while the window fills; the bit-serial divider sets this
// reset: window_len 1, history empty, no result pending
// a stalled receiver holds the result in the output register; the next
//   sample is still taken and waits in the divider until that word leaves
module simple_moving_average_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2*sma_pkg::DataW-1:0]     req_tdata,   // close_price, sample_tag
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [2*sma_pkg::DataW-1:0]     rsp_tdata,   // average, tag_out
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sma_pkg::CfgW-1:0]        csr_wdata
);

   sma_pkg::sma_cmd_type    cmd;
   sma_pkg::sma_status_type status;

   assign csr_ready = 1'b1;

   sma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sma_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- tb/tb_simple_moving_average_unit.sv -----
`timescale 1ns / 100ps

module tb_simple_moving_average_unit;

   localparam int PriceW      = sma_pkg::DataW;
   localparam int WinMax      = sma_pkg::MaxWindow;
   localparam int CodeW       = sma_pkg::CfgW;
   localparam int DrainCycles = 48;
   localparam int SampleGoal  = 800;

   typedef struct packed {
      logic [PriceW-1:0] tag;
      logic [PriceW-1:0] average;
   } avg_word_type;

   class sma_scoreboard;
      logic [PriceW-1:0] ring [WinMax];
      int unsigned       next_slot;
      int unsigned       held;
      int unsigned       win;
      logic [37:0]       total;
      avg_word_type      pending [$];
      int unsigned       errors;
      int unsigned       checked;
      int unsigned       samples;

      function new();
         win = 1;
         restart();
      endfunction

      function void restart();
         next_slot = 0;
         held      = 0;
         total     = '0;
      endfunction

      // length codes outside 1..64 are clamped
      function void set_window(logic [CodeW-1:0] code);
         if (code == '0) begin
            win = 1;
         end else if (int'(code) > WinMax) begin
            win = WinMax;
         end else begin
            win = code;
         end
         restart();
      endfunction

      function void note_sample(logic [PriceW-1:0] price, logic [PriceW-1:0] tag);
         avg_word_type want;
         samples++;
         if (held >= win) begin
            total -= ring[next_slot];
         end else begin
            held++;
         end
         ring[next_slot] = price;
         total += price;
         next_slot = (next_slot + 1 >= win) ? 0 : next_slot + 1;
         if (held >= win) begin
            want.average = PriceW'(total / win);
            want.tag     = tag;
            pending.push_back(want);
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 40) begin
            $display("mismatch at %0t: %s", $time, what);
         end
      endtask

      task check_result(logic [2*PriceW-1:0] word);
         avg_word_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("average word %h with none expected", word));
            return;
         end
         want = pending.pop_front();
         checked++;
         if (word[PriceW-1:0] !== want.average) begin
            report_mismatch($sformatf("average %h, expected %h",
                                      word[PriceW-1:0], want.average));
         end
         if (word[2*PriceW-1:PriceW] !== want.tag) begin
            report_mismatch($sformatf("tag %h, expected %h",
                                      word[2*PriceW-1:PriceW], want.tag));
         end
      endtask

      task close_out();
         if (pending.size() != 0) begin
            report_mismatch($sformatf("%0d averages never arrived", pending.size()));
         end
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [2*PriceW-1:0]     req_tdata;   // close_price, sample_tag
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [2*PriceW-1:0]     rsp_tdata;   // average, tag_out
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CodeW-1:0]        csr_wdata;

   sma_scoreboard sb = new();

   bit          gap_on;
   bit          stall_on;
   int          hold_request;
   int unsigned blocked_cycles;
   int unsigned window_writes;

   simple_moving_average_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // handshakes as seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.set_window(csr_wdata);
            window_writes++;
         end
         if (req_tvalid && req_tready) begin
            sb.note_sample(req_tdata[PriceW-1:0], req_tdata[2*PriceW-1:PriceW]);
         end
         if (req_tvalid && !req_tready) begin
            blocked_cycles++;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
      end
   end

   // receiver: random stall before each word, or one long hold when asked
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
         end else begin
            n = stall_on ? $urandom_range(0, 19) : 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout: run did not finish");
      $display("Simulation FAILED");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_sample(input logic [PriceW-1:0] price, input logic [PriceW-1:0] tag);
      int gap;
      gap = gap_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tag, price};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_window(input logic [CodeW-1:0] code);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= code;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PriceW-1:0] pick_price();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return PriceW'($urandom_range(0, 255));
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [CodeW-1:0] code_list [8];
      logic [CodeW-1:0] code;
      int               phase;
      int               count;
      int               eff;
      code_list    = '{7'd1, 7'd64, 7'd127, 7'd65, 7'd2, 7'd0, 7'd100, 7'd33};
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_wdata    = '0;
      gap_on       = 1'b0;
      stall_on     = 1'b0;
      hold_request = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // window of one straight out of reset
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample(32'h8000_0000, 32'h5555_aaaa);
      // zero length acts as one
      write_window('0);
      send_sample(32'h0001_0000, 32'haaaa_5555);
      send_sample(32'h1234_5678, 32'h0000_0001);
      // full-scale sum that needs the wide accumulator
      write_window(7'd3);
      repeat (4) send_sample('1, $urandom());
      send_sample(32'd1, 32'h0000_0002);
      send_sample(32'd2, 32'h0000_0003);
      // truncation toward zero
      gap_on   = 1'b1;
      stall_on = 1'b1;
      write_window(7'd2);
      send_sample(32'd0, 32'h0000_0004);
      send_sample(32'd1, 32'h0000_0005);
      send_sample('1, 32'h0000_0006);

      // output held off while the sender keeps pushing
      write_window(7'd1);
      gap_on       = 1'b0;
      stall_on     = 1'b0;
      hold_request = 600;
      repeat (40) send_sample(pick_price(), $urandom());

      phase = 0;
      while (sb.samples < SampleGoal) begin
         code = (phase < 8) ? code_list[phase] : CodeW'($urandom_range(0, 127));
         eff  = (code == 0) ? 1 : ((int'(code) > WinMax) ? WinMax : int'(code));
         count = eff + $urandom_range(10, 50);
         write_window(code);
         gap_on   = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         repeat (count) send_sample(pick_price(), $urandom());
         phase++;
      end

      drain();
      sb.close_out();
      $display("%0d samples sent, %0d averages checked, %0d window writes",
               sb.samples, sb.checked, window_writes);
      $display("input held off for %0d cycles while the block was busy or blocked",
               blocked_cycles);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sma_pkg.sv
hw/rtl/sma_ram.sv
hw/rtl/sma_ctrl.sv
hw/rtl/sma_datapath.sv
hw/rtl/simple_moving_average_unit.sv
tb/tb_simple_moving_average_unit.sv
